### rtl/core/emg_cp_pkg.sv
// shared types, constants and packet byte selection for the command packetizer
package emg_cp_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] START_MARK      = 8'hAA;
   localparam logic [7:0] PKT_MODE_OFF    = 8'h00;
   localparam logic [7:0] PKT_MODE_ACTIVE = 8'h02;
   localparam logic [7:0] PAD_BYTE        = 8'h00;
   localparam logic [8:0] CLOSE_CEIL      = 9'd250;
   localparam logic [7:0] RUN_MAX         = 8'd255;
   localparam logic [7:0] LEVEL_RESET     = 8'd128;

   localparam logic [7:0] BASELINE_RESET  = 8'd128;
   localparam logic [7:0] FSR_RESET       = 8'd50;
   localparam logic [7:0] CLOSE_RESET     = 8'd12;
   localparam logic [7:0] OPEN_RESET      = 8'd8;
   localparam logic [7:0] CONFIRM_RESET   = 8'd3;
   localparam logic [2:0] SHIFT_RESET     = 3'd2;

   // byte positions within a packet
   localparam logic [2:0] BYTE_START    = 3'd0;
   localparam logic [2:0] BYTE_MODE     = 3'd1;
   localparam logic [2:0] BYTE_PAD_A    = 3'd2;
   localparam logic [2:0] BYTE_PAD_B    = 3'd3;
   localparam logic [2:0] BYTE_CMD      = 3'd4;
   localparam logic [2:0] BYTE_FLAGS    = 3'd5;
   localparam logic [2:0] BYTE_CHECKSUM = 3'd6;

   typedef enum logic [2:0] {
      REG_REST_LEVEL    = 3'd0,
      REG_CONTACT_LIMIT = 3'd1,
      REG_CLOSE_DELTA   = 3'd2,
      REG_OPEN_DELTA    = 3'd3,
      REG_CONFIRM_COUNT = 3'd4,
      REG_FILTER_SHIFT  = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      CMD_HOLD  = 2'd0,
      CMD_OPEN  = 2'd1,
      CMD_CLOSE = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [7:0] rest_level;
      logic [7:0] contact_limit;
      logic [7:0] close_delta;
      logic [7:0] open_delta;
      logic [7:0] confirm_count;
      logic [2:0] filter_shift;
   } cfg_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [4:0] flags;
   } desc_type;

   function automatic logic [7:0] packet_byte_at(input desc_type d, input logic [2:0] idx);
      logic [7:0] pmode;
      logic [7:0] cmd_byte;
      logic [7:0] flag_byte;
      logic [7:0] result;
      pmode     = (d.flags != 5'd0) ? PKT_MODE_OFF : PKT_MODE_ACTIVE;
      cmd_byte  = {6'd0, d.cmd};
      flag_byte = {3'd0, d.flags};
      unique case (idx)
         BYTE_START:    result = START_MARK;
         BYTE_MODE:     result = pmode;
         BYTE_PAD_A:    result = PAD_BYTE;
         BYTE_PAD_B:    result = PAD_BYTE;
         BYTE_CMD:      result = cmd_byte;
         BYTE_FLAGS:    result = flag_byte;
         BYTE_CHECKSUM: result = pmode ^ PAD_BYTE ^ PAD_BYTE ^ cmd_byte ^ flag_byte;
         default:       result = PAD_BYTE;
      endcase
      return result;
   endfunction

endpackage

### rtl/core/emg_cp_req_if.sv
// sample frame channel
interface emg_cp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] force_a;
   logic [7:0] force_b;
   logic [7:0] force_c;
   logic [7:0] force_d;
   logic [7:0] force_e;
   logic [7:0] muscle_sample;
   logic       mode;

   modport source (output valid, force_a, force_b, force_c, force_d, force_e,
                   muscle_sample, mode, input ready);
   modport sink (input valid, force_a, force_b, force_c, force_d, force_e,
                 muscle_sample, mode, output ready);
endinterface

### rtl/core/emg_cp_rsp_if.sv
// packet byte channel
interface emg_cp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] packet_byte;
   logic       last_byte;

   modport source (output valid, packet_byte, last_byte, input ready);
   modport sink (input valid, packet_byte, last_byte, output ready);
endinterface

### rtl/core/emg_command_packetizer.sv
// Command packetizer: each accepted sample frame yields one seven-byte packet
// (start mark, mode, two pad bytes, command, contact flags, XOR checksum) on
// rsp, one byte per cycle while rsp.ready holds, as set by the byte serialiser.
// The front end decides a frame's command in the cycle it is accepted and
// hands it through a descriptor queue (QueueDepth entries), so frames are
// taken while earlier packets are still going out and the input stalls only
// while that queue is full. With the serialiser idle the first byte reaches
// rsp through the descriptor queue and then the output register. Configuration
// registers are written through csr_ and take effect on the next frame.
module emg_command_packetizer #(
   parameter int QueueDepth = emg_cp_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   emg_cp_req_if.sink   req,
   emg_cp_rsp_if.source rsp,
   input  logic       csr_write_enable,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_write_data
);

   emg_cp_pkg::cfg_type  cfg_ff, cfg_in;
   emg_cp_pkg::desc_type push_desc;
   emg_cp_pkg::desc_type pop_desc;
   logic q_push;
   logic q_full;
   logic q_pop;
   logic q_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            emg_cp_pkg::REG_REST_LEVEL:    cfg_in.rest_level    = csr_write_data;
            emg_cp_pkg::REG_CONTACT_LIMIT: cfg_in.contact_limit = csr_write_data;
            emg_cp_pkg::REG_CLOSE_DELTA:   cfg_in.close_delta   = csr_write_data;
            emg_cp_pkg::REG_OPEN_DELTA:    cfg_in.open_delta    = csr_write_data;
            emg_cp_pkg::REG_CONFIRM_COUNT: cfg_in.confirm_count = csr_write_data;
            emg_cp_pkg::REG_FILTER_SHIFT:  cfg_in.filter_shift  = csr_write_data[2:0];
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rest_level    <= emg_cp_pkg::BASELINE_RESET;
         cfg_ff.contact_limit <= emg_cp_pkg::FSR_RESET;
         cfg_ff.close_delta   <= emg_cp_pkg::CLOSE_RESET;
         cfg_ff.open_delta    <= emg_cp_pkg::OPEN_RESET;
         cfg_ff.confirm_count <= emg_cp_pkg::CONFIRM_RESET;
         cfg_ff.filter_shift  <= emg_cp_pkg::SHIFT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   emg_cp_front u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .req    (req),
      .q_full (q_full),
      .q_push (q_push),
      .q_desc (push_desc)
   );

   emg_cp_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (push_desc),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_desc  (pop_desc)
   );

   emg_cp_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_desc  (pop_desc),
      .q_pop   (q_pop),
      .rsp     (rsp)
   );

   // queue can never be full and empty at once
   a_queue_consistent: assert property (@(posedge clock) disable iff (reset)
      !(q_full && q_empty))
      else $error("descriptor queue full and empty together");

   // a new packet always opens with the start mark
   a_start_after_last: assert property (@(posedge clock) disable iff (reset)
      $past(rsp.valid && rsp.ready && rsp.last_byte) && rsp.valid
      |-> rsp.packet_byte == emg_cp_pkg::START_MARK && !rsp.last_byte)
      else $error("packet does not open with start mark");

   // checksum of mode, command and flags fits in five bits
   a_checksum_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.last_byte |-> rsp.packet_byte[7:5] == 3'd0)
      else $error("checksum byte out of range");

   // no descriptor is taken from an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("pop from empty descriptor queue");

endmodule

### rtl/core/emg_cp_front.sv
// front end: contact flags, smoothing filter, run counters and command decision
module emg_cp_front (
   input  logic                clock,
   input  logic                reset,
   input  emg_cp_pkg::cfg_type cfg,
   emg_cp_req_if.sink          req,
   input  logic                q_full,
   output logic                q_push,
   output emg_cp_pkg::desc_type q_desc
);

   logic [7:0] level_ff, level_in;
   logic [7:0] close_run_ff, close_run_in;
   logic [7:0] open_run_ff, open_run_in;

   logic              accept;
   logic [4:0]        flags;
   logic signed [9:0] diff;
   logic signed [9:0] step;
   logic signed [9:0] level_sum;
   logic [7:0]        level_next;
   logic [8:0]        close_sum;
   logic [8:0]        open_sum;
   logic [7:0]        close_thr;
   logic signed [9:0] open_thr_f;
   logic [7:0]        close_inc;
   logic [7:0]        open_inc;
   emg_cp_pkg::cmd_type cmd_filt;
   emg_cp_pkg::cmd_type cmd_man;
   emg_cp_pkg::cmd_type cmd_sel;

   assign req.ready = !q_full;
   assign accept    = req.valid && !q_full;

   assign flags[0] = req.force_a > cfg.contact_limit;
   assign flags[1] = req.force_b > cfg.contact_limit;
   assign flags[2] = req.force_c > cfg.contact_limit;
   assign flags[3] = req.force_d > cfg.contact_limit;
   assign flags[4] = req.force_e > cfg.contact_limit;

   // arithmetic shift gives the floor of the scaled difference
   assign diff       = $signed({2'b00, req.muscle_sample}) - $signed({2'b00, level_ff});
   assign step       = diff >>> cfg.filter_shift;
   assign level_sum  = $signed({2'b00, level_ff}) + step;
   assign level_next = level_sum[7:0];

   assign close_sum = {1'b0, cfg.rest_level} + {1'b0, cfg.close_delta};
   assign open_sum  = {1'b0, cfg.rest_level} + {1'b0, cfg.open_delta};
   assign close_thr = (close_sum > emg_cp_pkg::CLOSE_CEIL) ?
                      emg_cp_pkg::CLOSE_CEIL[7:0] : close_sum[7:0];
   // may reach minus one, in which case open never fires
   assign open_thr_f = (open_sum >= {1'b0, close_thr}) ?
                       ($signed({2'b00, close_thr}) - 10'sd1) : $signed({1'b0, open_sum});

   assign close_inc = (close_run_ff == emg_cp_pkg::RUN_MAX) ? close_run_ff : close_run_ff + 8'd1;
   assign open_inc  = (open_run_ff == emg_cp_pkg::RUN_MAX) ? open_run_ff : open_run_ff + 8'd1;

   always_comb begin
      cmd_filt     = emg_cp_pkg::CMD_HOLD;
      close_run_in = 8'd0;
      open_run_in  = 8'd0;
      if (level_next > close_thr) begin
         close_run_in = close_inc;
         if (close_inc >= cfg.confirm_count) begin
            cmd_filt     = emg_cp_pkg::CMD_CLOSE;
            close_run_in = 8'd0;
         end
      end else if ($signed({2'b00, level_next}) < open_thr_f) begin
         open_run_in = open_inc;
         if (open_inc >= cfg.confirm_count) begin
            cmd_filt    = emg_cp_pkg::CMD_OPEN;
            open_run_in = 8'd0;
         end
      end
   end

   always_comb begin
      if (req.muscle_sample > close_thr) begin
         cmd_man = emg_cp_pkg::CMD_CLOSE;
      end else if ({1'b0, req.muscle_sample} < open_sum) begin
         cmd_man = emg_cp_pkg::CMD_OPEN;
      end else begin
         cmd_man = emg_cp_pkg::CMD_HOLD;
      end
   end

   assign level_in = level_next;
   assign cmd_sel  = req.mode ? cmd_man : cmd_filt;

   always_comb begin
      q_desc.flags = flags;
      q_desc.cmd   = (flags != 5'd0) ? emg_cp_pkg::CMD_HOLD : cmd_sel;
   end
   assign q_push = accept;

   // manual mode leaves the filter and the run counts alone
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= emg_cp_pkg::LEVEL_RESET;
         close_run_ff <= 8'd0;
         open_run_ff  <= 8'd0;
      end else if (accept && !req.mode) begin
         level_ff     <= level_in;
         close_run_ff <= close_run_in;
         open_run_ff  <= open_run_in;
      end
   end

endmodule

### rtl/core/emg_cp_queue.sv
// small descriptor queue between front end and serialiser
module emg_cp_queue #(
   parameter int Depth = emg_cp_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  emg_cp_pkg::desc_type push_desc,
   output logic                 full,
   input  logic                 pop,
   output logic                 empty,
   output emg_cp_pkg::desc_type pop_desc
);

   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CW = $clog2(Depth + 1);
   localparam logic [AW-1:0] LAST_PTR = AW'(Depth - 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(Depth);

   emg_cp_pkg::desc_type entry_ff [Depth];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   assign full     = count_ff == DEPTH_CNT;
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_desc = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/core/emg_cp_back.sv
// back end: serialises one descriptor into seven packet bytes
module emg_cp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  emg_cp_pkg::desc_type q_desc,
   output logic                 q_pop,
   emg_cp_rsp_if.source         rsp
);

   emg_cp_pkg::desc_type desc_ff, desc_in;
   logic [2:0] idx_ff, idx_in;
   logic       busy_ff, busy_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       slot_free;

   // output register frees up when its byte is taken
   assign slot_free = !valid_ff || rsp.ready;

   always_comb begin
      desc_in  = desc_ff;
      idx_in   = idx_ff;
      busy_in  = busy_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      q_pop    = 1'b0;
      if (slot_free) begin
         if (busy_ff) begin
            valid_in = 1'b1;
            byte_in  = emg_cp_pkg::packet_byte_at(desc_ff, idx_ff);
            last_in  = idx_ff == emg_cp_pkg::BYTE_CHECKSUM;
            idx_in   = idx_ff + 3'd1;
            busy_in  = idx_ff != emg_cp_pkg::BYTE_CHECKSUM;
         end else if (!q_empty) begin
            q_pop    = 1'b1;
            desc_in  = q_desc;
            valid_in = 1'b1;
            byte_in  = emg_cp_pkg::packet_byte_at(q_desc, emg_cp_pkg::BYTE_START);
            last_in  = 1'b0;
            idx_in   = emg_cp_pkg::BYTE_MODE;
            busy_in  = 1'b1;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
      idx_ff  <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.packet_byte = byte_ff;
   assign rsp.last_byte   = last_ff;

endmodule

### test/emg_command_packetizer_tb.sv
// testbench for the command packetizer: sample frames checked against a packet predictor
module emg_command_packetizer_tb;

   localparam int   MAX_GAP         = 7;
   localparam int   HOLD_OFF_CYCLES = 100;
   localparam int   SETTLE_CYCLES   = 4;
   localparam int   TIMEOUT_LIMIT   = 1000000;
   localparam logic MODE_FILTERED   = 1'b0;
   localparam logic MODE_DIRECT     = 1'b1;

   typedef struct {
      logic [7:0] force_s [5];
      logic [7:0] muscle;
      logic       mode;
   } frame_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } packet_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write_enable;
   logic [2:0] csr_index;
   logic [7:0] csr_write_data;

   emg_cp_req_if req_ch ();
   emg_cp_rsp_if rsp_ch ();

   // predictor copy of the registers and the filter state
   emg_cp_pkg::cfg_type cur_cfg;
   int                  smoothed_level;
   int                  close_run;
   int                  open_run;
   packet_byte_type     packet_bytes_due [$];
   packet_byte_type     due_byte;
   int                  mismatch_count = 0;
   bit                  tx_idle_en = 1'b1;
   bit                  rx_idle_en = 1'b1;
   bit                  hold_off_req = 1'b0;

   emg_command_packetizer dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   initial begin
      #(TIMEOUT_LIMIT);
      $display("FAILURE");
      $finish;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch on %s at %0t: got %0h, wanted %0h", what, $realtime, got, want);
      mismatch_count++;
   endtask

   function automatic int close_limit();
      int limit;
      limit = int'(cur_cfg.rest_level) + int'(cur_cfg.close_delta);
      return (limit > int'(emg_cp_pkg::CLOSE_CEIL)) ? int'(emg_cp_pkg::CLOSE_CEIL) : limit;
   endfunction

   function automatic int open_limit();
      return int'(cur_cfg.rest_level) + int'(cur_cfg.open_delta);
   endfunction

   // works out the seven bytes of the packet for one accepted frame
   function automatic void compute_packet(input frame_type f);
      logic [4:0]          flags;
      emg_cp_pkg::cmd_type cmd;
      int                  close_th;
      int                  open_th;
      logic [7:0]          pmode;
      logic [7:0]          cmd_byte;
      logic [7:0]          flag_byte;
      logic [7:0]          bytes [7];
      flags    = '0;
      cmd      = emg_cp_pkg::CMD_HOLD;
      close_th = close_limit();
      open_th  = open_limit();
      for (int i = 0; i < 5; i++) flags[i] = f.force_s[i] > cur_cfg.contact_limit;
      if (f.mode == MODE_DIRECT) begin
         if (int'(f.muscle) > close_th) cmd = emg_cp_pkg::CMD_CLOSE;
         else if (int'(f.muscle) < open_th) cmd = emg_cp_pkg::CMD_OPEN;
      end else begin
         if (open_th >= close_th) open_th = close_th - 1;
         // arithmetic shift of the signed difference rounds towards minus infinity
         smoothed_level += (int'(f.muscle) - smoothed_level) >>> cur_cfg.filter_shift;
         if (smoothed_level > close_th) begin
            if (close_run < int'(emg_cp_pkg::RUN_MAX)) close_run++;
            open_run = 0;
            if (close_run >= int'(cur_cfg.confirm_count)) begin
               cmd       = emg_cp_pkg::CMD_CLOSE;
               close_run = 0;
            end
         end else if (smoothed_level < open_th) begin
            if (open_run < int'(emg_cp_pkg::RUN_MAX)) open_run++;
            close_run = 0;
            if (open_run >= int'(cur_cfg.confirm_count)) begin
               cmd      = emg_cp_pkg::CMD_OPEN;
               open_run = 0;
            end
         end else begin
            close_run = 0;
            open_run  = 0;
         end
      end
      // contact overrides whatever the detector decided
      if (flags != '0) begin
         pmode = emg_cp_pkg::PKT_MODE_OFF;
         cmd   = emg_cp_pkg::CMD_HOLD;
      end else begin
         pmode = emg_cp_pkg::PKT_MODE_ACTIVE;
      end
      cmd_byte  = {6'd0, cmd};
      flag_byte = {3'd0, flags};
      bytes = '{emg_cp_pkg::START_MARK, pmode, emg_cp_pkg::PAD_BYTE, emg_cp_pkg::PAD_BYTE,
                cmd_byte, flag_byte, pmode ^ cmd_byte ^ flag_byte};
      for (int i = 0; i < 7; i++) packet_bytes_due.push_back('{bytes[i], i == 6});
   endfunction

   function automatic frame_type make_frame(input logic [7:0] fa, fb, fc, fd, fe, muscle,
                                            input logic mode);
      frame_type f;
      f.force_s = '{fa, fb, fc, fd, fe};
      f.muscle  = muscle;
      f.mode    = mode;
      return f;
   endfunction

   task automatic send_frame(input frame_type f);
      int gap;
      gap = tx_idle_en ? $urandom_range(MAX_GAP, 0) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.force_a       <= f.force_s[0];
      req_ch.force_b       <= f.force_s[1];
      req_ch.force_c       <= f.force_s[2];
      req_ch.force_d       <= f.force_s[3];
      req_ch.force_e       <= f.force_s[4];
      req_ch.muscle_sample <= f.muscle;
      req_ch.mode          <= f.mode;
      do @(posedge clock); while (!req_ch.ready);
      compute_packet(f);
   endtask

   task automatic wait_for_packets();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (packet_bytes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input emg_cp_pkg::reg_index_type idx, input logic [7:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
   endtask

   task automatic apply_config(input emg_cp_pkg::cfg_type c);
      logic [4:0] junk;
      junk = 5'($urandom);
      write_csr(emg_cp_pkg::REG_REST_LEVEL, c.rest_level);
      write_csr(emg_cp_pkg::REG_CONTACT_LIMIT, c.contact_limit);
      write_csr(emg_cp_pkg::REG_CLOSE_DELTA, c.close_delta);
      write_csr(emg_cp_pkg::REG_OPEN_DELTA, c.open_delta);
      write_csr(emg_cp_pkg::REG_CONFIRM_COUNT, c.confirm_count);
      // upper bits of the shift write are don't care
      write_csr(emg_cp_pkg::REG_FILTER_SHIFT, {junk, c.filter_shift});
      @(negedge clock);
      csr_write_enable <= 1'b0;
      cur_cfg = c;
   endtask

   function automatic emg_cp_pkg::cfg_type random_config();
      emg_cp_pkg::cfg_type c;
      c.rest_level    = 8'($urandom_range(245, 10));
      c.contact_limit = 8'($urandom_range(255, 60));
      c.close_delta   = 8'($urandom_range(40, 0));
      c.open_delta    = 8'($urandom_range(40, 0));
      c.confirm_count = 8'($urandom_range(6, 1));
      c.filter_shift  = 3'($urandom_range(7, 0));
      return c;
   endfunction

   // runs of samples held above, below or between the thresholds, with some noise
   task automatic run_random_frames(input int count);
      frame_type f;
      int        run_left;
      int        run_cap;
      int        kind;
      int        lo;
      int        hi;
      run_left = 0;
      kind     = 0;
      for (int n = 0; n < count; n++) begin
         if (run_left == 0) begin
            kind    = $urandom_range(9, 0);
            run_cap = int'(cur_cfg.confirm_count) + 2;
            if (run_cap > 12) run_cap = 12;
            run_left = $urandom_range(run_cap, 1);
         end
         run_left--;
         if ($urandom_range(7, 0) == 0) begin
            for (int i = 0; i < 5; i++) f.force_s[i] = 8'($urandom_range(255, 0));
         end else begin
            for (int i = 0; i < 5; i++)
               f.force_s[i] = 8'($urandom_range(cur_cfg.contact_limit, 0));
         end
         f.mode = ($urandom_range(4, 0) == 0) ? MODE_DIRECT : MODE_FILTERED;
         if (kind <= 3) begin
            lo = close_limit() + 1;
            if (lo > 255) lo = 255;
            f.muscle = 8'($urandom_range(255, lo));
         end else if (kind <= 7) begin
            hi = open_limit() - 1;
            if (hi > 255) hi = 255;
            if (hi < 0) hi = 0;
            f.muscle = 8'($urandom_range(hi, 0));
         end else if (kind == 8) begin
            lo = open_limit();
            hi = close_limit();
            if (lo > 255) lo = 255;
            if (hi > 255) hi = 255;
            f.muscle = 8'($urandom_range(hi, lo));
         end else begin
            f.muscle = 8'($urandom_range(255, 0));
         end
         send_frame(f);
      end
   endtask

   task automatic test_directed();
      // manual thresholds at reset: close above 140, open below 136
      send_frame(make_frame(0, 0, 0, 0, 0, 0, MODE_DIRECT));
      send_frame(make_frame(50, 50, 50, 50, 50, 255, MODE_DIRECT));
      send_frame(make_frame(0, 0, 0, 0, 0, 140, MODE_DIRECT));
      send_frame(make_frame(0, 0, 0, 0, 0, 141, MODE_DIRECT));
      send_frame(make_frame(0, 0, 0, 0, 0, 136, MODE_DIRECT));
      send_frame(make_frame(0, 0, 0, 0, 0, 135, MODE_DIRECT));
      // contact on each channel while the filter keeps running
      send_frame(make_frame(255, 0, 0, 0, 0, 255, MODE_FILTERED));
      send_frame(make_frame(0, 255, 0, 0, 0, 255, MODE_FILTERED));
      send_frame(make_frame(0, 0, 255, 0, 0, 255, MODE_FILTERED));
      send_frame(make_frame(0, 0, 0, 255, 0, 255, MODE_FILTERED));
      send_frame(make_frame(0, 0, 0, 0, 255, 255, MODE_FILTERED));
      send_frame(make_frame(255, 255, 255, 255, 255, 255, MODE_DIRECT));
      send_frame(make_frame(0, 0, 51, 0, 0, 0, MODE_DIRECT));
      repeat (5) send_frame(make_frame(0, 0, 0, 0, 0, 255, MODE_FILTERED));
      repeat (5) send_frame(make_frame(0, 0, 0, 0, 0, 0, MODE_FILTERED));
      send_frame(make_frame(0, 0, 0, 0, 0, 128, MODE_FILTERED));
   endtask

   task automatic test_config_extremes();
      emg_cp_pkg::cfg_type settings [4];
      // zero everything: open threshold drops to minus one and any hit fires at once
      settings[0] = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 3'd0};
      settings[1] = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 3'd7};
      settings[2] = '{8'd10, 8'd128, 8'd0, 8'd255, 8'd1, 3'd1};
      settings[3] = '{8'd245, 8'd200, 8'd5, 8'd0, 8'd2, 3'd3};
      foreach (settings[i]) begin
         wait_for_packets();
         apply_config(settings[i]);
         tx_idle_en = 1'($urandom_range(1, 0));
         rx_idle_en = 1'($urandom_range(1, 0));
         run_random_frames(10);
      end
   endtask

   task automatic test_random_settings();
      for (int phase = 0; phase < 6; phase++) begin
         wait_for_packets();
         apply_config(random_config());
         tx_idle_en = (phase % 3) != 1;
         rx_idle_en = (phase % 3) != 2;
         run_random_frames(10);
      end
   endtask

   task automatic test_output_hold_off();
      wait_for_packets();
      tx_idle_en   = 1'b0;
      rx_idle_en   = 1'b1;
      hold_off_req = 1'b1;
      run_random_frames(12);
      wait_for_packets();
      tx_idle_en = 1'b1;
   endtask

   // packet byte sink with random stalls and an occasional long hold-off
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_req = 1'b0;
         end else begin
            stall = rx_idle_en ? $urandom_range(MAX_GAP, 0) : 0;
            if (stall > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (stall) @(negedge clock);
            end
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (packet_bytes_due.size() == 0) begin
            report_mismatch("byte with no packet due", int'(rsp_ch.packet_byte), 0);
         end else begin
            due_byte = packet_bytes_due.pop_front();
            if (rsp_ch.packet_byte !== due_byte.data)
               report_mismatch("packet_byte", int'(rsp_ch.packet_byte), int'(due_byte.data));
            if (rsp_ch.last_byte !== due_byte.last)
               report_mismatch("last_byte", int'(rsp_ch.last_byte), int'(due_byte.last));
         end
      end
   end

   initial begin
      req_ch.valid         = 1'b0;
      req_ch.force_a       = '0;
      req_ch.force_b       = '0;
      req_ch.force_c       = '0;
      req_ch.force_d       = '0;
      req_ch.force_e       = '0;
      req_ch.muscle_sample = '0;
      req_ch.mode          = MODE_FILTERED;
      csr_write_enable     = 1'b0;
      csr_index            = emg_cp_pkg::REG_REST_LEVEL;
      csr_write_data       = '0;
      cur_cfg = '{emg_cp_pkg::BASELINE_RESET, emg_cp_pkg::FSR_RESET,
                  emg_cp_pkg::CLOSE_RESET, emg_cp_pkg::OPEN_RESET,
                  emg_cp_pkg::CONFIRM_RESET, emg_cp_pkg::SHIFT_RESET};
      smoothed_level = int'(emg_cp_pkg::LEVEL_RESET);
      close_run      = 0;
      open_run       = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_config_extremes();
      test_random_settings();
      test_output_hold_off();
      wait_for_packets();

      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
